// ===== hdl/acs_pkg.sv =====
// ============================================================================
// acs_pkg
// Shared types, command codes and register defaults of the converter SPI
// command slave.
// ============================================================================
`default_nettype none

package acs_pkg;

    localparam int REGISTER_COUNT = 19;
    localparam int REG_AW         = $clog2(REGISTER_COUNT);
    localparam int ADDR_W         = 9;
    localparam int DELAY_W        = 16;
    localparam int SAMPLE_W       = 24;
    localparam int CFG_IDX_W      = 2;

    localparam int IDX_ID        = 0;
    localparam int IDX_STATUS    = 1;
    localparam int IDX_MODE3     = 5;
    localparam int READY_POS     = 2;

    localparam logic [7:0] OP_RESET     = 8'h06;
    localparam logic [7:0] OP_START     = 8'h08;
    localparam logic [7:0] OP_STOP      = 8'h0A;
    localparam logic [7:0] OP_RDATA     = 8'h12;
    localparam logic [7:0] OP_RREG      = 8'h20;
    localparam logic [7:0] OP_WREG      = 8'h40;
    localparam logic [7:0] CMD_MASK     = 8'hE0;
    localparam logic [7:0] FRAMING_MASK = 8'h03;

    localparam logic [7:0] STATUS_DEFAULT = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RCOUNT = 3'd1,
        PH_RDATA  = 3'd2,
        PH_WCOUNT = 3'd3,
        PH_WDATA  = 3'd4,
        PH_S1     = 3'd5,
        PH_S2     = 3'd6,
        PH_S3     = 3'd7
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE = 2'd0,
        CFG_STRICT = 2'd1,
        CFG_DELAY  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              restore;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              ready_set;
        logic              ready_clr;
    } rf_ctrl_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       data_ready;
        logic       warn_not_ready;
        logic       warn_unsupported;
        logic [7:0] warn_value;
        logic [2:0] phase_before;
        logic [2:0] phase_after;
    } result_t;

    function automatic logic [7:0] reg_default(input int unsigned idx);
        logic [7:0] val;
        case (idx)
            0:       val = 8'h70;
            1:       val = STATUS_DEFAULT;
            2:       val = 8'h24;
            3:       val = 8'h01;
            6:       val = 8'h05;
            12:      val = 8'h40;
            13:      val = 8'hFF;
            17:      val = 8'hFF;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/adc_spi_command_slave_top.sv =====
// ============================================================================
// adc_spi_command_slave_top
// SPI command slave of a 24-bit converter: one received byte or one tick
// per input word, one result word per input word.
// ============================================================================
// An input word is taken into the input register. One word per cycle
// unless the receiver stalls; the input register feeds the decoder and
// register file in one pass into the result register.
// Reset: synchronous, active low; registers return to device defaults and
// the command phase to idle.
`default_nettype none

module adc_spi_command_slave_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [7:0]                    s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [7:0]                    m_tx_byte,
    output logic                               m_data_ready,
    output logic                               m_warn_not_ready,
    output logic                               m_warn_unsupported,
    output logic      [7:0]                    m_warn_value,
    output logic      [2:0]                    m_phase_before,
    output logic      [2:0]                    m_phase_after,
    input  wire logic                          cfg_wr_en,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acs_pkg::SAMPLE_W-1:0]  cfg_wr_data
);

    logic                          in_valid_reg, in_valid_next;
    logic                          in_action_reg;
    logic [7:0]                    in_rx_reg;
    logic                          m_valid_reg, m_valid_next;
    acs_pkg::result_t              out_reg;
    acs_pkg::result_t              result;
    acs_pkg::rf_ctrl_t             rf_ctrl;
    logic [acs_pkg::ADDR_W-1:0]    rd_addr;
    logic [7:0]                    rd_data;
    logic                          status_ready;
    logic                          fire;

    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !fire);
    assign m_valid_next  = fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_rx_reg     <= s_rx_byte;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    acs_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .action       (in_action_reg),
        .rx_byte      (in_rx_reg),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .rd_data      (rd_data),
        .status_ready (status_ready),
        .rf_ctrl      (rf_ctrl),
        .rd_addr      (rd_addr),
        .result       (result)
    );

    acs_regfile u_regfile (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (rf_ctrl),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .status_ready (status_ready)
    );

    assign m_valid            = m_valid_reg;
    assign m_tx_byte          = out_reg.tx_byte;
    assign m_data_ready       = out_reg.data_ready;
    assign m_warn_not_ready   = out_reg.warn_not_ready;
    assign m_warn_unsupported = out_reg.warn_unsupported;
    assign m_warn_value       = out_reg.warn_value;
    assign m_phase_before     = out_reg.phase_before;
    assign m_phase_after      = out_reg.phase_after;

endmodule

`default_nettype wire

// ===== hdl/acs_regfile.sv =====
// ============================================================================
// acs_regfile
// Device register file with power-on defaults, one write port, one read
// port and direct set and clear of the ready bit in the status register.
// ============================================================================
`default_nettype none

module acs_regfile (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire acs_pkg::rf_ctrl_t         ctrl,
    input  wire logic [acs_pkg::ADDR_W-1:0] rd_addr,
    output logic      [7:0]                rd_data,
    output logic                           status_ready
);

    logic [7:0] rf_reg [acs_pkg::REGISTER_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.restore) begin
            for (int i = 0; i < acs_pkg::REGISTER_COUNT; i++) begin
                rf_reg[i] <= acs_pkg::reg_default(i);
            end
        end else begin
            if (ctrl.wr_en
                && ctrl.wr_addr < acs_pkg::ADDR_W'(acs_pkg::REGISTER_COUNT)
                && ctrl.wr_addr != acs_pkg::ADDR_W'(acs_pkg::IDX_ID)) begin
                rf_reg[ctrl.wr_addr[acs_pkg::REG_AW-1:0]] <= ctrl.wr_data;
            end
            if (ctrl.ready_clr) begin
                rf_reg[acs_pkg::IDX_STATUS][acs_pkg::READY_POS] <= 1'b0;
            end else if (ctrl.ready_set) begin
                rf_reg[acs_pkg::IDX_STATUS][acs_pkg::READY_POS] <= 1'b1;
            end
        end
    end

    assign rd_data = (rd_addr < acs_pkg::ADDR_W'(acs_pkg::REGISTER_COUNT))
                   ? rf_reg[rd_addr[acs_pkg::REG_AW-1:0]] : 8'h00;

    assign status_ready = rf_reg[acs_pkg::IDX_STATUS][acs_pkg::READY_POS];

endmodule

`default_nettype wire

// ===== hdl/acs_engine.sv =====
// ============================================================================
// acs_engine
// Command decoder and sequencer: holds the command phase, burst pointer,
// ready countdown and configuration, and forms one result per word.
// ============================================================================
`default_nettype none

module acs_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire logic                          action,
    input  wire logic [7:0]                    rx_byte,
    input  wire logic                          cfg_wr_en,
    input  wire logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acs_pkg::SAMPLE_W-1:0]  cfg_wr_data,
    input  wire logic [7:0]                    rd_data,
    input  wire logic                          status_ready,
    output acs_pkg::rf_ctrl_t                  rf_ctrl,
    output logic      [acs_pkg::ADDR_W-1:0]    rd_addr,
    output acs_pkg::result_t                   result
);

    acs_pkg::phase_t                  phase_reg, phase_next;
    logic                             converting_reg, converting_next;
    logic [acs_pkg::DELAY_W-1:0]      countdown_reg, countdown_next;
    logic [acs_pkg::ADDR_W-1:0]       baddr_reg, baddr_next;
    logic [7:0]                       brem_reg, brem_next;
    logic [7:0]                       held_tx_reg, held_tx_next;
    logic [acs_pkg::SAMPLE_W-1:0]     sample_reg;
    logic                             strict_reg;
    logic [acs_pkg::DELAY_W-1:0]      delay_reg;

    logic [acs_pkg::ADDR_W-1:0]       baddr_inc;
    logic [acs_pkg::ADDR_W-1:0]       start_slot;
    logic [acs_pkg::ADDR_W-1:0]       start_addr;
    logic [7:0]                       tx;
    logic                             warn_nr;
    logic                             warn_un;
    logic [7:0]                       warn_val;
    logic                             ready_after;

    assign baddr_inc  = baddr_reg + acs_pkg::ADDR_W'(1);
    assign start_slot = {4'b0000, rx_byte[4:0]};
    assign start_addr = (start_slot >= acs_pkg::ADDR_W'(acs_pkg::REGISTER_COUNT))
                      ? acs_pkg::ADDR_W'(acs_pkg::REGISTER_COUNT - 1) : start_slot;
    assign rd_addr    = (phase_reg == acs_pkg::PH_RDATA) ? baddr_inc : baddr_reg;

    always_comb begin
        phase_next      = phase_reg;
        converting_next = converting_reg;
        countdown_next  = countdown_reg;
        baddr_next      = baddr_reg;
        brem_next       = brem_reg;
        held_tx_next    = held_tx_reg;
        rf_ctrl         = '0;
        tx              = 8'h00;
        warn_nr         = 1'b0;
        warn_un         = 1'b0;
        warn_val        = 8'h00;

        if (fire) begin
            if (action) begin
                if (converting_reg && countdown_reg != '0) begin
                    countdown_next = countdown_reg - acs_pkg::DELAY_W'(1);
                    if (countdown_reg == acs_pkg::DELAY_W'(1)) begin
                        rf_ctrl.ready_set = 1'b1;
                    end
                end
                tx = held_tx_reg;
            end else begin
                case (phase_reg)
                    acs_pkg::PH_IDLE: begin
                        if (rx_byte == acs_pkg::OP_RESET) begin
                            rf_ctrl.restore = 1'b1;
                            converting_next = 1'b0;
                            countdown_next  = '0;
                        end else if (rx_byte == acs_pkg::OP_START) begin
                            converting_next = 1'b1;
                            if (delay_reg == '0) begin
                                rf_ctrl.ready_set = 1'b1;
                                countdown_next    = '0;
                            end else begin
                                rf_ctrl.ready_clr = 1'b1;
                                countdown_next    = delay_reg;
                            end
                        end else if (rx_byte == acs_pkg::OP_STOP) begin
                            converting_next   = 1'b0;
                            rf_ctrl.ready_clr = 1'b1;
                        end else if (rx_byte == acs_pkg::OP_RDATA) begin
                            if (!status_ready) begin
                                warn_nr = strict_reg;
                            end else begin
                                tx         = sample_reg[23:16];
                                phase_next = acs_pkg::PH_S1;
                            end
                        end else if ((rx_byte & acs_pkg::CMD_MASK) == acs_pkg::OP_RREG) begin
                            baddr_next = start_addr;
                            phase_next = acs_pkg::PH_RCOUNT;
                        end else if ((rx_byte & acs_pkg::CMD_MASK) == acs_pkg::OP_WREG) begin
                            baddr_next = start_addr;
                            phase_next = acs_pkg::PH_WCOUNT;
                        end
                    end
                    acs_pkg::PH_RCOUNT: begin
                        brem_next  = rx_byte;
                        tx         = rd_data;
                        phase_next = acs_pkg::PH_RDATA;
                    end
                    acs_pkg::PH_RDATA: begin
                        if (brem_reg != 8'h00) begin
                            baddr_next = baddr_inc;
                            brem_next  = brem_reg - 8'd1;
                            tx         = rd_data;
                        end else begin
                            phase_next = acs_pkg::PH_IDLE;
                        end
                    end
                    acs_pkg::PH_WCOUNT: begin
                        brem_next  = rx_byte;
                        phase_next = acs_pkg::PH_WDATA;
                    end
                    acs_pkg::PH_WDATA: begin
                        rf_ctrl.wr_en   = 1'b1;
                        rf_ctrl.wr_addr = baddr_reg;
                        rf_ctrl.wr_data = rx_byte;
                        if (strict_reg
                            && baddr_reg == acs_pkg::ADDR_W'(acs_pkg::IDX_MODE3)
                            && (rx_byte & acs_pkg::FRAMING_MASK) != 8'h00) begin
                            warn_un  = 1'b1;
                            warn_val = rx_byte;
                        end
                        if (brem_reg != 8'h00) begin
                            baddr_next = baddr_inc;
                            brem_next  = brem_reg - 8'd1;
                        end else begin
                            phase_next = acs_pkg::PH_IDLE;
                        end
                    end
                    acs_pkg::PH_S1: begin
                        tx         = sample_reg[15:8];
                        phase_next = acs_pkg::PH_S2;
                    end
                    acs_pkg::PH_S2: begin
                        tx         = sample_reg[7:0];
                        phase_next = acs_pkg::PH_S3;
                    end
                    default: begin
                        if (converting_reg) begin
                            if (delay_reg == '0) begin
                                rf_ctrl.ready_set = 1'b1;
                                countdown_next    = '0;
                            end else begin
                                rf_ctrl.ready_clr = 1'b1;
                                countdown_next    = delay_reg;
                            end
                        end
                        phase_next = acs_pkg::PH_IDLE;
                    end
                endcase
                held_tx_next = tx;
            end
        end

        if (cfg_wr_en && cfg_index == acs_pkg::CFG_DELAY) begin
            countdown_next = '0;
            if (cfg_wr_data[acs_pkg::DELAY_W-1:0] != '0) begin
                rf_ctrl.ready_clr = 1'b1;
            end
        end

        // Status ready bit as it stands once this word has been applied.
        if (rf_ctrl.restore) begin
            ready_after = acs_pkg::STATUS_DEFAULT[acs_pkg::READY_POS];
        end else if (rf_ctrl.wr_en
                     && rf_ctrl.wr_addr == acs_pkg::ADDR_W'(acs_pkg::IDX_STATUS)) begin
            ready_after = rf_ctrl.wr_data[acs_pkg::READY_POS];
        end else if (rf_ctrl.ready_clr) begin
            ready_after = 1'b0;
        end else if (rf_ctrl.ready_set) begin
            ready_after = 1'b1;
        end else begin
            ready_after = status_ready;
        end

        result.tx_byte          = tx;
        result.data_ready       = ready_after;
        result.warn_not_ready   = warn_nr;
        result.warn_unsupported = warn_un;
        result.warn_value       = warn_val;
        result.phase_before     = phase_reg;
        result.phase_after      = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= acs_pkg::PH_IDLE;
            converting_reg <= 1'b0;
            countdown_reg  <= '0;
            baddr_reg      <= '0;
            brem_reg       <= '0;
            held_tx_reg    <= '0;
            sample_reg     <= '0;
            strict_reg     <= 1'b0;
            delay_reg      <= '0;
        end else begin
            phase_reg      <= phase_next;
            converting_reg <= converting_next;
            countdown_reg  <= countdown_next;
            baddr_reg      <= baddr_next;
            brem_reg       <= brem_next;
            held_tx_reg    <= held_tx_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    acs_pkg::CFG_SAMPLE: begin
                        sample_reg <= cfg_wr_data;
                    end
                    acs_pkg::CFG_STRICT: begin
                        strict_reg <= cfg_wr_data[0];
                    end
                    acs_pkg::CFG_DELAY: begin
                        delay_reg <= cfg_wr_data[acs_pkg::DELAY_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ============================================================================
// tb
// Self-checking testbench for the converter SPI command slave. Words are
// sent on the input channel and predicted by a behavioral copy of the
// command decoder. Each result word is compared field by field with the
// oldest prediction. The run covers directed command sequences, then
// random command traffic under several register settings, with sender
// gaps and receiver stalls.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 40;
    localparam int DEFAULT_COUNT = 19;
    localparam logic [8*DEFAULT_COUNT-1:0] POWER_ON = {
        8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h01, 8'h24, 8'h01, 8'h70};

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = 1'b0;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_tx_byte;
    logic                 m_data_ready;
    logic                 m_warn_not_ready;
    logic                 m_warn_unsupported;
    logic [7:0]           m_warn_value;
    logic [2:0]           m_phase_before;
    logic [2:0]           m_phase_after;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]  cfg_wr_data = '0;

    adc_spi_command_slave_top u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_tx_byte          (m_tx_byte),
        .m_data_ready       (m_data_ready),
        .m_warn_not_ready   (m_warn_not_ready),
        .m_warn_unsupported (m_warn_unsupported),
        .m_warn_value       (m_warn_value),
        .m_phase_before     (m_phase_before),
        .m_phase_after      (m_phase_after),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Behavioral copy of the slave state.
    logic [7:0]          dev_regs [REGISTER_COUNT];
    phase_t              cur_phase;
    logic                converting;
    logic [DELAY_W-1:0]  ready_count;
    logic [ADDR_W-1:0]   burst_addr;
    logic [7:0]          burst_left;
    logic [7:0]          last_tx;
    logic [SAMPLE_W-1:0] cfg_sample;
    logic                cfg_strict;
    logic [DELAY_W-1:0]  cfg_delay;

    result_t expected_words[$];
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    bit      valid_hi = 1'b0;
    int      quiet_cycles = 0;

    function automatic void restore_defaults();
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            dev_regs[i] = (i < DEFAULT_COUNT) ? POWER_ON[8*i +: 8] : 8'h00;
        end
        converting  = 1'b0;
        cur_phase   = PH_IDLE;
        ready_count = '0;
    endfunction

    function automatic void arm_ready();
        if (cfg_delay == 0) begin
            dev_regs[IDX_STATUS][READY_POS] = 1'b1;
            ready_count = '0;
        end else begin
            dev_regs[IDX_STATUS][READY_POS] = 1'b0;
            ready_count = cfg_delay;
        end
    endfunction

    function automatic logic [ADDR_W-1:0] burst_start(input logic [7:0] cmd);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(cmd[4:0]);
        if (a >= REGISTER_COUNT) begin
            a = ADDR_W'(REGISTER_COUNT - 1);
        end
        return a;
    endfunction

    function automatic logic [7:0] read_reg(input logic [ADDR_W-1:0] a);
        return (a < REGISTER_COUNT) ? dev_regs[a] : 8'h00;
    endfunction

    function automatic void apply_config(input cfg_idx_t idx,
                                         input logic [SAMPLE_W-1:0] data);
        case (idx)
            CFG_SAMPLE: begin
                cfg_sample = data;
            end
            CFG_STRICT: begin
                cfg_strict = data[0];
            end
            CFG_DELAY: begin
                cfg_delay   = data[DELAY_W-1:0];
                ready_count = '0;
                if (cfg_delay != 0) begin
                    dev_regs[IDX_STATUS][READY_POS] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic result_t predict_word(input logic act, input logic [7:0] rx);
        result_t r;
        phase_t  ph;
        logic [7:0] tx;
        r  = '0;
        ph = cur_phase;
        tx = 8'h00;
        if (act) begin
            if (converting && ready_count != 0) begin
                ready_count = ready_count - 1'b1;
                if (ready_count == 0) begin
                    dev_regs[IDX_STATUS][READY_POS] = 1'b1;
                end
            end
            tx = last_tx;
        end else begin
            case (ph)
                PH_IDLE: begin
                    if (rx == OP_RESET) begin
                        restore_defaults();
                    end else if (rx == OP_START) begin
                        converting = 1'b1;
                        arm_ready();
                    end else if (rx == OP_STOP) begin
                        converting = 1'b0;
                        dev_regs[IDX_STATUS][READY_POS] = 1'b0;
                    end else if (rx == OP_RDATA) begin
                        if (!dev_regs[IDX_STATUS][READY_POS]) begin
                            r.warn_not_ready = cfg_strict;
                        end else begin
                            tx = cfg_sample[23:16];
                            cur_phase = PH_S1;
                        end
                    end else if ((rx & CMD_MASK) == OP_RREG) begin
                        burst_addr = burst_start(rx);
                        cur_phase  = PH_RCOUNT;
                    end else if ((rx & CMD_MASK) == OP_WREG) begin
                        burst_addr = burst_start(rx);
                        cur_phase  = PH_WCOUNT;
                    end
                end
                PH_RCOUNT: begin
                    burst_left = rx;
                    tx = read_reg(burst_addr);
                    cur_phase = PH_RDATA;
                end
                PH_RDATA: begin
                    if (burst_left != 0) begin
                        burst_addr = burst_addr + 1'b1;
                        burst_left = burst_left - 1'b1;
                        tx = read_reg(burst_addr);
                    end else begin
                        cur_phase = PH_IDLE;
                    end
                end
                PH_WCOUNT: begin
                    burst_left = rx;
                    cur_phase = PH_WDATA;
                end
                PH_WDATA: begin
                    if (burst_addr != IDX_ID && burst_addr < REGISTER_COUNT) begin
                        if (cfg_strict && burst_addr == IDX_MODE3
                                && (rx & FRAMING_MASK) != 0) begin
                            r.warn_unsupported = 1'b1;
                            r.warn_value = rx;
                        end
                        dev_regs[burst_addr] = rx;
                    end
                    if (burst_left != 0) begin
                        burst_addr = burst_addr + 1'b1;
                        burst_left = burst_left - 1'b1;
                    end else begin
                        cur_phase = PH_IDLE;
                    end
                end
                PH_S1: begin
                    tx = cfg_sample[15:8];
                    cur_phase = PH_S2;
                end
                PH_S2: begin
                    tx = cfg_sample[7:0];
                    cur_phase = PH_S3;
                end
                default: begin
                    if (converting) begin
                        arm_ready();
                    end
                    cur_phase = PH_IDLE;
                end
            endcase
            last_tx = tx;
        end
        r.tx_byte      = tx;
        r.data_ready   = dev_regs[IDX_STATUS][READY_POS];
        r.phase_before = ph;
        r.phase_after  = cur_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT) begin
            $display("%0t ns: word %0d: %s: got 0x%0h, expected 0x%0h",
                     $time, n_checked, what, got, want);
        end
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with no prediction", m_tx_byte, 0);
            end else begin
                want = expected_words.pop_front();
                compare_field("tx_byte", m_tx_byte, want.tx_byte);
                compare_field("data_ready", m_data_ready, want.data_ready);
                compare_field("warn_not_ready", m_warn_not_ready, want.warn_not_ready);
                compare_field("warn_unsupported", m_warn_unsupported,
                              want.warn_unsupported);
                compare_field("warn_value", m_warn_value, want.warn_value);
                compare_field("phase_before", m_phase_before, want.phase_before);
                compare_field("phase_after", m_phase_after, want.phase_after);
            end
            n_checked++;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic act, input logic [7:0] rx);
        while ($urandom_range(99) < idle_pct) begin
            if (valid_hi) begin
                s_valid <= 1'b0;
                valid_hi = 1'b0;
            end
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        valid_hi  = 1'b1;
        s_action  <= act;
        s_rx_byte <= rx;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_words.push_back(predict_word(act, rx));
        n_sent++;
    endtask

    task automatic drain_link();
        if (valid_hi) begin
            s_valid <= 1'b0;
            valid_hi = 1'b0;
        end
        while (expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [SAMPLE_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        apply_config(idx, data);
    endtask

    task automatic set_config(input logic [SAMPLE_W-1:0] sample, input logic strict,
                              input logic [DELAY_W-1:0] delay);
        drain_link();
        write_cfg(CFG_SAMPLE, sample);
        write_cfg(CFG_STRICT, SAMPLE_W'(strict));
        write_cfg(CFG_DELAY, SAMPLE_W'(delay));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] burst_length();
        return ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
    endfunction

    // Feeds bytes until the slave is back in the idle phase, with ticks mixed
    // in and an occasional early abandon that turns the next command into data.
    task automatic finish_sequence();
        int  pick;
        bit  quit;
        quit = 1'b0;
        while (cur_phase != PH_IDLE && !quit) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                quit = 1'b1;
            end else if (pick < 13) begin
                send_word(1'b1, 8'($urandom_range(255)));
            end else begin
                send_word(1'b0, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic random_traffic(input int n_words);
        int         stop_at;
        int         pick;
        logic [4:0] addr;
        stop_at = n_sent + n_words;
        while (n_sent < stop_at) begin
            pick = $urandom_range(99);
            addr = ($urandom_range(3) == 0) ? 5'(IDX_MODE3) : 5'($urandom_range(31));
            if (pick < 14) begin
                repeat ($urandom_range(1, 8)) send_word(1'b1, 8'($urandom_range(255)));
            end else if (pick < 24) begin
                send_word(1'b0, OP_START);
            end else if (pick < 29) begin
                send_word(1'b0, OP_STOP);
            end else if (pick < 32) begin
                send_word(1'b0, OP_RESET);
            end else if (pick < 50) begin
                send_word(1'b0, OP_RDATA);
            end else if (pick < 66) begin
                send_word(1'b0, OP_RREG | {3'b000, addr});
                send_word(1'b0, burst_length());
            end else if (pick < 84) begin
                send_word(1'b0, OP_WREG | {3'b000, addr});
                send_word(1'b0, burst_length());
            end else begin
                send_word(1'b0, 8'($urandom_range(255)));
            end
            finish_sequence();
        end
    endtask

    task automatic set_traffic(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    task automatic test_command_decode();
        set_config(24'hFFFFFF, 1'b1, 16'd0);
        set_traffic(0, 0);
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, OP_RDATA);
        send_word(1'b0, OP_START);
        send_word(1'b0, OP_RDATA);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, OP_WREG | 8'(IDX_MODE3));
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h03);
        send_word(1'b0, OP_WREG | 8'(IDX_ID));
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h55);
        send_word(1'b0, OP_RREG | 8'h1F);
        send_word(1'b0, 8'h01);
        send_word(1'b0, 8'hAA);
        send_word(1'b0, 8'hAA);
        send_word(1'b0, OP_WREG | 8'h1F);
        send_word(1'b0, 8'h02);
        send_word(1'b0, 8'hA5);
        send_word(1'b0, 8'h5A);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, OP_STOP);
        send_word(1'b0, OP_RESET);
    endtask

    task automatic test_ready_countdown();
        set_config(24'h000000, 1'b0, 16'd2);
        set_traffic(0, 0);
        send_word(1'b0, OP_START);
        send_word(1'b0, OP_RDATA);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        send_word(1'b1, 8'h00);
        send_word(1'b0, OP_RDATA);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        send_word(1'b0, OP_RDATA);
        send_word(1'b0, OP_STOP);
        send_word(1'b0, OP_WREG | 8'(IDX_STATUS));
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h04);
        send_word(1'b0, OP_RDATA);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        send_word(1'b0, OP_RREG | 8'(IDX_STATUS));
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
    endtask

    task automatic test_busy_link();
        set_config(SAMPLE_W'($urandom), 1'b1, 16'd0);
        set_traffic(0, 0);
        random_traffic(150);
    endtask

    task automatic test_sender_gaps();
        set_config(SAMPLE_W'($urandom), 1'b0, 16'd3);
        set_traffic(50, 0);
        random_traffic(150);
    endtask

    task automatic test_receiver_stalls();
        set_config(SAMPLE_W'($urandom), 1'b1, 16'd1);
        set_traffic(0, 50);
        random_traffic(150);
    endtask

    task automatic test_mixed_gaps();
        set_config(SAMPLE_W'($urandom), 1'b1, DELAY_W'($urandom_range(2, 10)));
        set_traffic(22, 22);
        random_traffic(150);
    endtask

    task automatic test_longest_delay();
        set_config(24'h000000, 1'b0, 16'hFFFF);
        set_traffic(0, 0);
        random_traffic(60);
    endtask

    task automatic test_full_scale();
        set_config(24'hFFFFFF, 1'b1, 16'd0);
        set_traffic(22, 22);
        random_traffic(90);
    endtask

    initial begin
        restore_defaults();
        burst_addr = '0;
        burst_left = '0;
        last_tx    = '0;
        cfg_sample = '0;
        cfg_strict = 1'b0;
        cfg_delay  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_command_decode();
        test_ready_countdown();
        test_busy_link();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_gaps();
        test_longest_delay();
        test_full_scale();
        drain_link();
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
